// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg - shared types and codes of the stream command parser
// Request and response payloads, the queue entry and the event/error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

   // event kinds
   localparam logic [3:0] EV_TONE    = 4'd0;
   localparam logic [3:0] EV_VOLUME  = 4'd1;
   localparam logic [3:0] EV_DATA    = 4'd2;
   localparam logic [3:0] EV_WAIT    = 4'd3;
   localparam logic [3:0] EV_LOOP    = 4'd4;
   localparam logic [3:0] EV_END     = 4'd5;
   localparam logic [3:0] EV_REPEAT  = 4'd6;
   localparam logic [3:0] EV_ERROR   = 4'd7;
   localparam logic [3:0] EV_SUMMARY = 4'd8;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd2;
   localparam logic [2:0] ERR_BLOCK_PAST = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

   // opcodes and masks
   localparam logic [7:0] OP_END      = 8'h00;
   localparam logic [7:0] OP_LOOP     = 8'h01;
   localparam logic [7:0] OP_REPEAT_LO = 8'h08;
   localparam logic [5:0] REPEAT_BIAS = 6'd4;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [1:0]  channel;
      logic [5:0]  value;
      logic [15:0] command_offset;
      logic [23:0] frame_number;
      logic [15:0] repeat_offset;
      logic [5:0]  repeat_length;
      logic [2:0]  error_code;
      logic        compressed_seen;
      logic [7:0]  loop_count;
      logic        end_seen;
      logic        extra_data;
   } rsp_type;

   // everything one request produces: an optional event and an optional summary
   typedef struct packed {
      rsp_type     event_rsp;
      logic        has_event;
      logic        has_summary;
      logic [15:0] sum_loop_offset;
      logic [23:0] sum_frames;
      logic [15:0] sum_end_offset;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/psc_front.sv =====
// ----------------------------------------------------------------------------
// psc_front - command classifier
// Holds the parse state, decodes each byte and builds one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_front #(
   parameter int OFFSET_BITS = 16,
   parameter int FRAME_BITS  = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire psc_pkg::req_type  req_data,
   output logic                   q_push,
   output psc_pkg::entry_type     q_data
);
   import psc_pkg::*;

   localparam int CMP_W = (OFFSET_BITS > 17) ? OFFSET_BITS : 17;

   typedef enum logic [3:0] {
      PH_CMD  = 4'b0001,
      PH_LOW  = 4'b0010,
      PH_HIGH = 4'b0100,
      PH_HALT = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS:0]   pos_ff, pos_in;
   logic [5:0]             pcmd_ff, pcmd_in;
   logic [7:0]             plow_ff, plow_in;
   logic [OFFSET_BITS-1:0] poff_ff, poff_in;
   logic [FRAME_BITS-1:0]  frames_ff, frames_in;
   logic                   comp_ff, comp_in;
   logic [7:0]             loops_ff, loops_in;
   logic [OFFSET_BITS-1:0] lpos_ff, lpos_in;
   logic [OFFSET_BITS-1:0] epos_ff, epos_in;
   logic                   end_ff, end_in;
   logic                   extra_ff, extra_in;

   logic [7:0]              b;
   logic                    fin;
   logic                    at_limit;
   logic [OFFSET_BITS-1:0]  here;
   logic [FRAME_BITS:0]     frames_sum;
   logic [15:0]             boff;
   logic [5:0]              blen;
   logic                    block_past;
   rsp_type                 ev;
   logic                    has_ev;

   // fixed-width views of parameter-width values
   logic [OFFSET_BITS+15:0] here_w, poff_w, lpos_w, epos_w;
   logic [FRAME_BITS+23:0]  frames_w, frames_new_w;

   assign b        = req_data.stream_byte;
   assign fin      = req_data.final_byte;
   assign at_limit = pos_ff[OFFSET_BITS];
   assign here     = pos_ff[OFFSET_BITS-1:0];
   assign pos_in   = at_limit ? pos_ff : pos_ff + (OFFSET_BITS+1)'(1);

   assign here_w       = {16'b0, here};
   assign poff_w       = {16'b0, poff_ff};
   assign lpos_w       = {16'b0, lpos_in};
   assign epos_w       = {16'b0, epos_in};
   assign frames_w     = {24'b0, frames_ff};
   assign frames_new_w = {24'b0, frames_in};

   assign frames_sum = {1'b0, frames_ff} + (FRAME_BITS+1)'({1'b0, b[2:0]} + 4'd1);
   assign boff       = {b, plow_ff};
   assign blen       = pcmd_ff - REPEAT_BIAS;
   assign block_past = (CMP_W'(boff) + CMP_W'(blen)) > CMP_W'(poff_ff);

   always_comb begin
      phase_in  = phase_ff;
      pcmd_in   = pcmd_ff;
      plow_in   = plow_ff;
      poff_in   = poff_ff;
      frames_in = frames_ff;
      comp_in   = comp_ff;
      loops_in  = loops_ff;
      lpos_in   = lpos_ff;
      epos_in   = epos_ff;
      end_in    = end_ff;
      extra_in  = extra_ff;
      ev        = '0;
      has_ev    = 1'b0;
      ev.command_offset = here_w[15:0];
      ev.frame_number   = frames_w[23:0];
      case (phase_ff)
         PH_HALT: begin
            extra_in = 1'b1;
         end
         PH_CMD: begin
            has_ev = 1'b1;
            if (at_limit) begin
               phase_in          = PH_HALT;
               ev.event_kind     = EV_ERROR;
               ev.error_code     = ERR_TOO_LONG;
               ev.command_offset = '0;
            end else if (b[7]) begin
               ev.event_kind = b[4] ? EV_VOLUME : EV_TONE;
               ev.channel    = b[6:5];
               ev.value      = {2'b0, b[3:0]};
            end else if (b[6]) begin
               ev.event_kind = EV_DATA;
               ev.value      = b[5:0];
            end else if (b[5:3] == 3'b111) begin
               ev.event_kind = EV_WAIT;
               ev.value      = {3'b0, b[2:0]};
               frames_in     = frames_sum[FRAME_BITS] ? '1 : frames_sum[FRAME_BITS-1:0];
            end else if (b == OP_LOOP) begin
               ev.event_kind = EV_LOOP;
               if (loops_ff != 8'hFF) begin
                  loops_in = loops_ff + 8'd1;
               end
               lpos_in = here;
            end else if (b == OP_END) begin
               ev.event_kind = EV_END;
               end_in        = 1'b1;
               epos_in       = here;
               phase_in      = PH_HALT;
            end else if (b < OP_REPEAT_LO) begin
               ev.event_kind = EV_ERROR;
               ev.error_code = ERR_UNKNOWN;
               phase_in      = PH_HALT;
            end else begin
               // opener of a three-byte repeat block
               pcmd_in = b[5:0];
               poff_in = here;
               if (fin) begin
                  ev.event_kind = EV_ERROR;
                  ev.error_code = ERR_TRUNCATED;
                  phase_in      = PH_HALT;
               end else begin
                  has_ev   = 1'b0;
                  phase_in = PH_LOW;
               end
            end
         end
         PH_LOW: begin
            plow_in           = b;
            ev.command_offset = poff_w[15:0];
            if (fin) begin
               has_ev        = 1'b1;
               ev.event_kind = EV_ERROR;
               ev.error_code = ERR_TRUNCATED;
               phase_in      = PH_HALT;
            end else begin
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            has_ev            = 1'b1;
            comp_in           = 1'b1;
            ev.command_offset = poff_w[15:0];
            ev.repeat_offset  = boff;
            ev.repeat_length  = blen;
            if (block_past) begin
               ev.event_kind = EV_ERROR;
               ev.error_code = ERR_BLOCK_PAST;
               phase_in      = PH_HALT;
            end else begin
               ev.event_kind = EV_REPEAT;
               phase_in      = PH_CMD;
            end
         end
         default: begin
            phase_in = PH_CMD;
         end
      endcase
      // flags as they stand after this byte
      ev.compressed_seen = comp_in;
      ev.loop_count      = loops_in;
      ev.end_seen        = end_in;
      ev.extra_data      = extra_in;
   end

   always_comb begin
      q_data                 = '0;
      q_data.event_rsp       = ev;
      q_data.has_event       = has_ev;
      q_data.has_summary     = fin;
      q_data.sum_loop_offset = lpos_w[15:0];
      q_data.sum_frames      = frames_new_w[23:0];
      q_data.sum_end_offset  = epos_w[15:0];
   end

   assign q_push = accept && (has_ev || fin);

   // the final byte returns everything to the reset state
   always_ff @(posedge clock) begin
      if (reset || (accept && fin)) begin
         phase_ff  <= PH_CMD;
         pos_ff    <= '0;
         pcmd_ff   <= '0;
         plow_ff   <= '0;
         poff_ff   <= '0;
         frames_ff <= '0;
         comp_ff   <= 1'b0;
         loops_ff  <= '0;
         lpos_ff   <= '0;
         epos_ff   <= '0;
         end_ff    <= 1'b0;
         extra_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         pcmd_ff   <= pcmd_in;
         plow_ff   <= plow_in;
         poff_ff   <= poff_in;
         frames_ff <= frames_in;
         comp_ff   <= comp_in;
         loops_ff  <= loops_in;
         lpos_ff   <= lpos_in;
         epos_ff   <= epos_in;
         end_ff    <= end_in;
         extra_ff  <= extra_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psc_queue.sv =====
// ----------------------------------------------------------------------------
// psc_queue - entry queue between classifier and emitter
// Small register queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire psc_pkg::entry_type  push_data,
   output logic                     full,
   input  wire logic                pop,
   output psc_pkg::entry_type       pop_data,
   output logic                     empty
);
   import psc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ff];

   assign wr_in    = do_push ? wr_ff + PTR_W'(1) : wr_ff;
   assign rd_in    = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
   assign count_in = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psc_back.sv =====
// ----------------------------------------------------------------------------
// psc_back - response emitter
// Unpacks each queue entry into its event and summary responses through
// a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire psc_pkg::entry_type  q_data,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output psc_pkg::rsp_type         rsp_data,
   output logic                     empty,
   input  wire logic                pop
);
   import psc_pkg::*;

   rsp_type rsp_ff, rsp_in;
   logic    valid_ff, valid_in;
   logic    sub_ff, sub_in;     // event half of the head entry already sent
   logic    load;
   logic    take_event;
   rsp_type summ;

   always_comb begin
      summ                 = '0;
      summ.event_kind      = EV_SUMMARY;
      summ.command_offset  = q_data.sum_loop_offset;
      summ.frame_number    = q_data.sum_frames;
      summ.repeat_offset   = q_data.sum_end_offset;
      summ.compressed_seen = q_data.event_rsp.compressed_seen;
      summ.loop_count      = q_data.event_rsp.loop_count;
      summ.end_seen        = q_data.event_rsp.end_seen;
      summ.extra_data      = q_data.event_rsp.extra_data;
   end

   assign load       = !valid_ff || pop;
   assign take_event = q_data.has_event && !sub_ff;

   always_comb begin
      rsp_in   = rsp_ff;
      valid_in = valid_ff && !pop;
      sub_in   = sub_ff;
      q_pop    = 1'b0;
      if (load && !q_empty) begin
         valid_in = 1'b1;
         if (take_event) begin
            rsp_in = q_data.event_rsp;
            if (q_data.has_summary) begin
               sub_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end else begin
            rsp_in = summ;
            sub_in = 1'b0;
            q_pop  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
   assign empty    = !valid_ff;

endmodule

`default_nettype wire

// ===== rtl/psg_stream_command_parser.sv =====
// ----------------------------------------------------------------------------
// psg_stream_command_parser - sound-chip command stream decoder
// Decodes a byte stream of latch, data, wait, loop, end and repeat-block
// commands into event responses, with a summary on the final byte.
//
//   channel    direction  handshake      payload
//   request    in         push / full    req_data  (psc_pkg::req_type)
//   response   out        pop / empty    rsp_data  (psc_pkg::rsp_type)
//
// One request accepted per cycle while full is low. A response passes through
// the queue and then the response register to the result ports; a request with
// both an event and a summary yields the event and then the summary, one after
// the other through the single response register.
// A four-entry queue between classifier and emitter absorbs output stalls;
// full rises only when it fills.
// Reset is synchronous and returns the parser to the start of a stream.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_stream_command_parser #(
   parameter int OFFSET_BITS = 16,
   parameter int FRAME_BITS  = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire psc_pkg::req_type  req_data,
   output logic                   empty,
   input  wire logic              pop,
   output psc_pkg::rsp_type       rsp_data
);
   import psc_pkg::*;

   logic      accept;
   logic      q_push;
   entry_type q_in;
   entry_type q_out;
   logic      q_empty;
   logic      q_pop;

   assign accept = push && !full;

   psc_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   psc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   psc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_out),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

`default_nettype wire
